// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk_i, reset on rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/trf_pkg.sv =====
// ----------------------------------------------------------------------------
// trf_pkg
// telnet receive filter: command codes, result type and packing widths
// ----------------------------------------------------------------------------
package trf_pkg;

  localparam logic [7:0] CODE_IAC  = 8'd255;
  localparam logic [7:0] CODE_DONT = 8'd254;
  localparam logic [7:0] CODE_DO   = 8'd253;
  localparam logic [7:0] CODE_WONT = 8'd252;
  localparam logic [7:0] CODE_WILL = 8'd251;
  localparam logic [7:0] CODE_SB   = 8'd250;
  localparam logic [7:0] CODE_SE   = 8'd240;
  localparam logic [7:0] OPT_WINDOW = 8'd31;

  localparam int unsigned KIND_W  = 1;
  localparam int unsigned TDATA_W = 40;

  localparam logic [KIND_W-1:0] KIND_DATA   = 1'b0;
  localparam logic [KIND_W-1:0] KIND_WINDOW = 1'b1;

  typedef struct packed {
    logic [15:0]       window_rows;
    logic [15:0]       window_columns;
    logic [7:0]        user_byte;
    logic [KIND_W-1:0] result_kind;
  } trf_result_t;

  typedef struct packed {
    logic consume;
    logic out_ready;
  } trf_flow_t;

endpackage

// ===== rtl/trf_in_stage.sv =====
// ----------------------------------------------------------------------------
// trf_in_stage
// input register: holds one received byte until the parser takes it
// ----------------------------------------------------------------------------
module trf_in_stage import trf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  trf_flow_t  flow_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || flow_i.consume;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

// ===== rtl/trf_parser.sv =====
// ----------------------------------------------------------------------------
// trf_parser
// telnet command state machine, subnegotiation capture and window report
// ----------------------------------------------------------------------------
module trf_parser import trf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        fire_i,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  output trf_result_t res_o
);

  localparam logic [2:0] PH_DATA     = 3'd0;
  localparam logic [2:0] PH_IAC      = 3'd1;
  localparam logic [2:0] PH_OPTION   = 3'd2;
  localparam logic [2:0] PH_SB_OPT   = 3'd3;
  localparam logic [2:0] PH_SB_DATA  = 3'd4;
  localparam logic [2:0] PH_SB_IAC   = 3'd5;
  localparam logic [2:0] PH_SB_OPIAC = 3'd6;

  localparam logic [2:0] KEEP_MAX = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  opt_q, opt_d;
  logic [2:0]  cnt_q, cnt_d, cnt_1;
  logic [31:0] pay_q, pay_d, pay_1;
  logic        en_q;
  logic        clr, keep_iac, keep_byte, finish;

  always_comb begin
    phase_d     = phase_q;
    opt_d       = opt_q;
    clr         = 1'b0;
    keep_iac    = 1'b0;
    keep_byte   = 1'b0;
    finish      = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      PH_IAC: begin
        phase_d = PH_DATA;
        if (rx_byte_i == CODE_IAC) begin
          res_valid_o         = 1'b1;
          res_o.result_kind   = KIND_DATA;
          res_o.user_byte     = CODE_IAC;
        end else if (rx_byte_i inside {[CODE_WILL:CODE_DONT]}) begin
          phase_d = PH_OPTION;
        end else if (rx_byte_i == CODE_SB) begin
          clr     = 1'b1;
          opt_d   = '0;
          phase_d = PH_SB_OPT;
        end
      end
      PH_OPTION: begin
        phase_d = PH_DATA;
      end
      PH_SB_OPT: begin
        opt_d   = rx_byte_i;
        phase_d = (rx_byte_i == CODE_IAC) ? PH_SB_OPIAC : PH_SB_DATA;
      end
      PH_SB_OPIAC: begin
        if (rx_byte_i == CODE_SE) begin
          finish = 1'b1;
        end else if (rx_byte_i == CODE_IAC) begin
          phase_d = PH_SB_IAC;
        end else begin
          keep_byte = 1'b1;
          phase_d   = PH_SB_DATA;
        end
      end
      PH_SB_DATA: begin
        if (rx_byte_i == CODE_IAC) begin
          phase_d = PH_SB_IAC;
        end else begin
          keep_byte = 1'b1;
        end
      end
      PH_SB_IAC: begin
        if (rx_byte_i == CODE_SE) begin
          finish = 1'b1;
        end else begin
          keep_iac = 1'b1;
          if (rx_byte_i != CODE_IAC) begin
            keep_byte = 1'b1;
            phase_d   = PH_SB_DATA;
          end
        end
      end
      default: begin
        if (rx_byte_i == CODE_IAC) begin
          phase_d = PH_IAC;
        end else begin
          phase_d           = PH_DATA;
          res_valid_o       = 1'b1;
          res_o.result_kind = KIND_DATA;
          res_o.user_byte   = rx_byte_i;
        end
      end
    endcase

    if (finish) begin
      phase_d = PH_DATA;
      if (opt_q == OPT_WINDOW && cnt_q >= KEEP_MAX && en_q) begin
        res_valid_o          = 1'b1;
        res_o.result_kind    = KIND_WINDOW;
        res_o.window_columns = pay_q[31:16];
        res_o.window_rows    = pay_q[15:0];
      end
    end

    // first kept byte: the escaped iac
    pay_1 = pay_q;
    cnt_1 = cnt_q;
    if (keep_iac && cnt_q < KEEP_MAX) begin
      pay_1 = {pay_q[23:0], CODE_IAC};
      cnt_1 = cnt_q + 3'd1;
    end

    // second kept byte: the received byte
    pay_d = pay_1;
    cnt_d = cnt_1;
    if (keep_byte && cnt_1 < KEEP_MAX) begin
      pay_d = {pay_1[23:0], rx_byte_i};
      cnt_d = cnt_1 + 3'd1;
    end

    if (clr) begin
      pay_d = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DATA;
      opt_q   <= '0;
      cnt_q   <= '0;
      pay_q   <= '0;
      en_q    <= 1'b1;
    end else begin
      if (fire_i) begin
        phase_q <= phase_d;
        opt_q   <= opt_d;
        cnt_q   <= cnt_d;
        pay_q   <= pay_d;
      end
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== rtl/trf_out_stage.sv =====
// ----------------------------------------------------------------------------
// trf_out_stage
// result register toward the output stream; m_axis_tready reaches the input side combinationally
// ----------------------------------------------------------------------------
module trf_out_stage import trf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic        res_valid_i,
  input  trf_result_t res_i,
  output trf_flow_t   flow_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output trf_result_t out_o
);

  logic        valid_q, valid_d;
  trf_result_t res_q;

  assign flow_o.out_ready = !valid_q || out_ready_i;
  assign flow_o.consume   = byte_valid_i && flow_o.out_ready;

  always_comb begin
    valid_d = valid_q;
    if (flow_o.out_ready) begin
      valid_d = flow_o.consume && res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_o.consume && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

// ===== rtl/telnet_receive_filter.sv =====
// ----------------------------------------------------------------------------
// telnet_receive_filter
// strips telnet commands from a received byte stream, reports window size
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one received byte per transfer in tdata[7:0]
//   m_axis carries zero or one result per input byte; tuser is the kind
//   (0 user data, 1 window size), tdata holds user byte, columns, rows
//   cfg_we_i with cfg_wdata_i sets window reporting, write only when idle
// path: an accepted byte is held in the input register, then passes the parser
//   into the result register, whose contents drive m_axis
// throughput: one byte per cycle while m_axis_tready is high, set by the single
//   parser pass between the input register and the result register
// reset: both registers empty, parser in the data phase, reporting on
// stall: when m_axis_tready is low the result holds, the input register
//   still takes one more byte, then s_axis_tready drops until the result
//   transfer happens; bytes that produce no result still need the result
//   register free to pass the parser
// ----------------------------------------------------------------------------
module telnet_receive_filter import trf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // user_byte, window_columns, window_rows
  output logic [KIND_W-1:0]  m_axis_tuser    // result_kind
);

  `include "assert_macros.svh"

  trf_flow_t   flow;
  logic        in_valid_q;
  logic [7:0]  in_byte;
  logic        res_valid;
  trf_result_t res;
  trf_result_t out_res;

  trf_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .flow_i       (flow),
    .byte_valid_o (in_valid_q),
    .byte_o       (in_byte)
  );

  trf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (flow.consume),
    .rx_byte_i   (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  trf_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_valid_q),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .flow_o       (flow),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (out_res)
  );

  assign m_axis_tdata = {out_res.window_rows, out_res.window_columns, out_res.user_byte};
  assign m_axis_tuser = out_res.result_kind;

  `ASSERT_IMPL(a_ready_low_full, !s_axis_tready, in_valid_q && !flow.consume,
    "input side stalled without a held byte")
  `ASSERT_IMPL(a_window_no_byte, m_axis_tvalid && m_axis_tuser == KIND_WINDOW,
    m_axis_tdata[7:0] == 8'd0, "window result carries a data byte")
  `ASSERT_IMPL(a_data_no_window, m_axis_tvalid && m_axis_tuser == KIND_DATA,
    m_axis_tdata[TDATA_W-1:8] == '0, "data result carries window size")
  `ASSERT_IMPL(a_consume_frees, flow.consume && !s_axis_tvalid, ##1 !in_valid_q,
    "consumed byte not released")

endmodule

// ===== verif/telnet_receive_filter_test.sv =====
// ----------------------------------------------------------------------------
// telnet_receive_filter_test
// drives telnet byte streams with commands, escapes and window size
// subnegotiations into the filter, predicts every data byte and window
// report, and compares each result transfer field by field in order
// ----------------------------------------------------------------------------
module telnet_receive_filter_test import trf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES  = 80;

  typedef enum logic [2:0] {
    PH_DATA, PH_IAC, PH_OPTION, PH_SB_OPT, PH_SB_DATA, PH_SB_IAC, PH_SB_OPIAC
  } parse_phase_e;

  class telnet_scoreboard;
    trf_result_t  expected_outputs[$];
    bit           report_enable;
    parse_phase_e phase;
    logic [7:0]   sb_option;
    logic [2:0]   sb_count;
    logic [31:0]  sb_payload;
    int unsigned  mismatches;

    function new();
      report_enable = 1'b1;
      phase         = PH_DATA;
      sb_option     = '0;
      sb_count      = '0;
      sb_payload    = '0;
      mismatches    = 0;
    endfunction

    function void set_report_enable(bit v);
      report_enable = v;
    endfunction

    function int unsigned pending();
      return expected_outputs.size();
    endfunction

    function void report(string msg);
      $display("error: %s", msg);
      mismatches++;
    endfunction

    function void store_payload(logic [7:0] b);
      if (sb_count < 3'd4) begin
        sb_payload = {sb_payload[23:0], b};
        sb_count++;
      end
    endfunction

    function bit close_subneg(output trf_result_t r);
      bit hit;
      r   = '0;
      hit = (sb_option == OPT_WINDOW) && (sb_count >= 3'd4) && report_enable;
      if (hit) begin
        r.result_kind    = KIND_WINDOW;
        r.window_columns = sb_payload[31:16];
        r.window_rows    = sb_payload[15:0];
      end
      phase = PH_DATA;
      return hit;
    endfunction

    function void note_byte(logic [7:0] b);
      trf_result_t r;
      bit          has;
      r   = '0;
      has = 1'b0;
      case (phase)
        PH_IAC: begin
          if (b == CODE_IAC) begin
            phase       = PH_DATA;
            r.result_kind = KIND_DATA;
            r.user_byte = 8'hFF;
            has         = 1'b1;
          end else if (b >= CODE_WILL && b <= CODE_DONT) begin
            phase = PH_OPTION;
          end else if (b == CODE_SB) begin
            sb_option  = '0;
            sb_count   = '0;
            sb_payload = '0;
            phase      = PH_SB_OPT;
          end else begin
            phase = PH_DATA;
          end
        end
        PH_OPTION: phase = PH_DATA;
        PH_SB_OPT: begin
          sb_option = b;
          phase     = (b == CODE_IAC) ? PH_SB_OPIAC : PH_SB_DATA;
        end
        PH_SB_OPIAC: begin
          if (b == CODE_SE) begin
            has = close_subneg(r);
          end else if (b == CODE_IAC) begin
            phase = PH_SB_IAC;
          end else begin
            store_payload(b);
            phase = PH_SB_DATA;
          end
        end
        PH_SB_DATA: begin
          if (b == CODE_IAC) phase = PH_SB_IAC;
          else store_payload(b);
        end
        PH_SB_IAC: begin
          if (b == CODE_SE) begin
            has = close_subneg(r);
          end else begin
            store_payload(CODE_IAC);
            if (b != CODE_IAC) begin
              store_payload(b);
              phase = PH_SB_DATA;
            end
          end
        end
        default: begin
          if (b == CODE_IAC) begin
            phase = PH_IAC;
          end else begin
            phase         = PH_DATA;
            r.result_kind = KIND_DATA;
            r.user_byte   = b;
            has           = 1'b1;
          end
        end
      endcase
      if (has) expected_outputs.push_back(r);
    endfunction

    function void check_result(trf_result_t got);
      trf_result_t exp;
      if (expected_outputs.size() == 0) begin
        report($sformatf("unexpected result kind %0d data %0h", got.result_kind,
                         {got.window_rows, got.window_columns, got.user_byte}));
        return;
      end
      exp = expected_outputs.pop_front();
      if (got.result_kind !== exp.result_kind)
        report($sformatf("result kind %0d, want %0d", got.result_kind, exp.result_kind));
      if (got.user_byte !== exp.user_byte)
        report($sformatf("user byte %0h, want %0h", got.user_byte, exp.user_byte));
      if (got.window_columns !== exp.window_columns)
        report($sformatf("columns %0d, want %0d", got.window_columns, exp.window_columns));
      if (got.window_rows !== exp.window_rows)
        report($sformatf("rows %0d, want %0d", got.window_rows, exp.window_rows));
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic               cfg_wdata_i   = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]  m_axis_tuser;

  telnet_scoreboard sb;
  bit               src_idle_on  = 1'b1;
  bit               sink_idle_on = 1'b1;
  bit               hold_req     = 1'b0;
  int unsigned      bytes_sent   = 0;

  telnet_receive_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("telnet_receive_filter: mismatch");
    $finish;
  end

  // transfer monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result({m_axis_tdata, m_axis_tuser});
    end
  end

  // result receiver
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_report_enable(input bit v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_report_enable(v);
  endtask

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 7))
      0:       return CODE_IAC;
      1:       return CODE_SE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_subneg();
    logic [7:0]  opt;
    int unsigned len;
    case ($urandom_range(0, 9))
      6, 7:    opt = 8'($urandom_range(0, 255));
      8:       opt = CODE_IAC;
      default: opt = OPT_WINDOW;
    endcase
    len = ($urandom_range(0, 9) < 6) ? 4 : $urandom_range(0, 7);
    send_byte(CODE_IAC);
    send_byte(CODE_SB);
    send_byte(opt);
    if (opt == CODE_IAC && $urandom_range(0, 1) == 0) begin
      send_byte(CODE_SE);
      return;
    end
    for (int i = 0; i < len; i++) send_byte(pick_payload());
    if ($urandom_range(0, 19) != 0) begin
      send_byte(CODE_IAC);
      send_byte(CODE_SE);
    end
  endtask

  task automatic send_random_sequence();
    case ($urandom_range(0, 19))
      8: begin
        send_byte(CODE_IAC);
        send_byte(CODE_IAC);
      end
      9, 10: begin
        send_byte(CODE_IAC);
        send_byte(8'($urandom_range(CODE_WILL, CODE_DONT)));
        send_byte(8'($urandom_range(0, 255)));
      end
      11: begin
        send_byte(CODE_IAC);
        send_byte(8'($urandom_range(0, 249)));
      end
      12, 13, 14, 15, 16, 17: send_subneg();
      18, 19: send_byte(8'($urandom_range(0, 255)));
      default: send_byte(8'($urandom_range(0, 254)));
    endcase
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_random_sequence();
  endtask

  initial begin
    logic [7:0] directed[$];
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // literal data, escaped 0xff, option commands, stray commands,
    // window size report, option byte iac, raw payload iac and long payload
    directed = '{8'h00, CODE_IAC, CODE_IAC, CODE_IAC, CODE_DONT, CODE_IAC,
                 CODE_IAC, 8'hF1, CODE_IAC, CODE_SE,
                 CODE_IAC, CODE_SB, OPT_WINDOW, 8'h00, 8'h50, 8'h00, 8'h18,
                 CODE_IAC, CODE_SE,
                 CODE_IAC, CODE_SB, CODE_IAC, CODE_SE,
                 CODE_IAC, CODE_SB, OPT_WINDOW, 8'h01, CODE_IAC, 8'h07, 8'h03,
                 8'h04, CODE_IAC, CODE_SE, 8'h7F};
    foreach (directed[i]) send_byte(directed[i]);

    run_random(400);
    write_report_enable(1'b0);
    hold_req = 1'b1;
    run_random(400);
    write_report_enable(1'b1);
    run_random(400);
    write_report_enable(1'b0);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    run_random(175);
    write_report_enable(1'b1);
    run_random(175);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("telnet_receive_filter: match");
    end else begin
      $display("telnet_receive_filter: mismatch");
    end
    $finish;
  end

endmodule
